// ----- rtl/mck_pkg.sv -----
// Package with shared types, constants and the character code table of the Morse keyer.
`default_nettype none
package mck_pkg;

  localparam int TICK_BITS_DEF = 8;
  localparam int QDEPTH        = 2;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_UNIT_TICKS   = 3'd0;
  localparam logic [2:0] REG_DASH_UNITS   = 3'd1;
  localparam logic [2:0] REG_LETTER_GAP   = 3'd2;
  localparam logic [2:0] REG_WORD_GAP     = 3'd3;
  localparam logic [2:0] REG_INVERT_LED   = 3'd4;

  // Register reset values
  localparam logic [7:0] UNIT_TICKS_RST   = 8'd24;
  localparam logic [2:0] DASH_UNITS_RST   = 3'd3;
  localparam logic [2:0] LETTER_GAP_RST   = 3'd5;
  localparam logic [2:0] WORD_GAP_RST     = 3'd2;
  localparam logic       INVERT_LED_RST   = 1'b0;

  // Input opcodes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [5:0] DIGIT_BASE = 6'd26;

  localparam int CODE_ENTRIES = 36;

  // Element count in [7:5], pattern in [4:0], first element at bit 4, 1 = dash
  localparam logic [7:0] CODE_TABLE [CODE_ENTRIES] = '{
    8'h48, 8'h90, 8'h94, 8'h70, 8'h20, 8'h84, 8'h78, 8'h80, 8'h40, 8'h8E,
    8'h74, 8'h88, 8'h58, 8'h50, 8'h7C, 8'h8C, 8'h9A, 8'h68, 8'h60, 8'h30,
    8'h64, 8'h82, 8'h6C, 8'h92, 8'h96, 8'h98,
    8'hBF, 8'hAF, 8'hA7, 8'hA3, 8'hA1, 8'hA0, 8'hB0, 8'hB8, 8'hBC, 8'hBE
  };

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_LETTER,
    KIND_SPACE,
    KIND_OTHER
  } item_kind_e;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] code;
  } item_t;

  typedef struct packed {
    logic [7:0] unit_ticks;
    logic [2:0] dash_units;
    logic [2:0] letter_gap_units;
    logic [2:0] word_gap_extra_units;
    logic       invert_led;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/mck_front.sv -----
// Front end: classify each input item and look up the letter code word.
`default_nettype none
module mck_front
  import mck_pkg::*;
(
  input  wire logic       op_i,
  input  wire logic [7:0] char_code_i,
  output item_t           item_o
);

  logic [5:0] idx;
  logic       is_letter;
  logic       is_digit;
  logic [7:0] ofs_letter;
  logic [7:0] ofs_digit;

  assign is_letter  = (char_code_i >= CH_UPPER_A) && (char_code_i <= CH_UPPER_Z);
  assign is_digit   = (char_code_i >= CH_ZERO) && (char_code_i <= CH_NINE);
  assign ofs_letter = char_code_i - CH_UPPER_A;
  assign ofs_digit  = char_code_i - CH_ZERO;

  always_comb begin
    idx         = is_letter ? ofs_letter[5:0] : (DIGIT_BASE + ofs_digit[5:0]);
    item_o.code = 8'd0;
    if (op_i == OP_TICK) begin
      item_o.kind = KIND_TICK;
    end else if (is_letter || is_digit) begin
      item_o.kind = KIND_LETTER;
      item_o.code = CODE_TABLE[idx];
    end else if (char_code_i == CH_SPACE) begin
      item_o.kind = KIND_SPACE;
    end else begin
      item_o.kind = KIND_OTHER;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mck_queue.sv -----
// Short queue of classified items between front end and back end.
`default_nettype none
module mck_queue
  import mck_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  item_t      item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output item_t      item_o
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t            mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mck_back.sv -----
// Back end: keyer timing state, result computation and output register.
`default_nettype none
module mck_back
  import mck_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  cfg_t       cfg_i,
  input  wire logic  item_valid_i,
  input  item_t      item_i,
  output logic       item_pop_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output logic       led_level_o,
  output logic       busy_res_o,
  output logic       rejected_o
);

  localparam int UW = (TICK_BITS > 8) ? TICK_BITS : 8;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MARK,
    PH_ESPACE,
    PH_GAP
  } phase_e;

  typedef struct packed {
    logic [4:0] pattern;
    logic [2:0] elements;
    logic [2:0] units;
  } elem_t;

  phase_e               phase_q, phase_d;
  logic [TICK_BITS-1:0] tick_q, tick_d;
  logic [2:0]           units_q, units_d;
  logic [4:0]           pat_q, pat_d;
  logic [2:0]           elem_q, elem_d;
  logic                 out_valid_q;
  logic                 led_q, led_d;
  logic                 busy_q, busy_d;
  logic                 rej_q, rej_d;

  logic [UW-1:0]        u_ext;
  logic [UW-1:0]        lim_ext;
  logic [UW-1:0]        len_ext;
  logic [TICK_BITS:0]   t_inc;
  logic [2:0]           units_dec;
  logic [2:0]           gap_letter;
  elem_t                es_cur;
  elem_t                es_new;

  function automatic elem_t start_elem(logic [4:0] pat, logic [2:0] cnt, logic [2:0] dash);
    elem_t r;
    r.pattern  = {pat[3:0], 1'b0};
    r.elements = cnt - 3'd1;
    r.units    = pat[4] ? ((dash == 3'd0) ? 3'd1 : dash) : 3'd1;
    return r;
  endfunction

  assign u_ext      = UW'((cfg_i.unit_ticks == 8'd0) ? 8'd1 : cfg_i.unit_ticks);
  assign lim_ext    = UW'({TICK_BITS{1'b1}});
  assign len_ext    = (u_ext > lim_ext) ? lim_ext : u_ext;
  assign t_inc      = {1'b0, tick_q} + 1'b1;
  assign units_dec  = units_q - 3'd1;
  assign gap_letter = (cfg_i.letter_gap_units == 3'd0) ? 3'd0 : cfg_i.letter_gap_units - 3'd1;
  assign es_cur     = start_elem(pat_q, elem_q, cfg_i.dash_units);
  assign es_new     = start_elem(item_i.code[4:0], item_i.code[7:5], cfg_i.dash_units);

  // Pop whenever the output register is free or being drained
  assign item_pop_o = item_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    units_d = units_q;
    pat_d   = pat_q;
    elem_d  = elem_q;
    rej_d   = 1'b0;
    case (item_i.kind)
      KIND_LETTER, KIND_SPACE, KIND_OTHER: begin
        if (phase_q != PH_IDLE) begin
          rej_d = 1'b1;
        end else if (item_i.kind == KIND_LETTER) begin
          pat_d  = item_i.code[4:0];
          elem_d = item_i.code[7:5];
          if (item_i.code[7:5] != 3'd0) begin
            pat_d   = es_new.pattern;
            elem_d  = es_new.elements;
            units_d = es_new.units;
            tick_d  = '0;
            phase_d = PH_MARK;
          end
        end else if (item_i.kind == KIND_SPACE) begin
          tick_d = '0;
          if (cfg_i.word_gap_extra_units == 3'd0) begin
            phase_d = PH_IDLE;
            units_d = 3'd0;
          end else begin
            phase_d = PH_GAP;
            units_d = cfg_i.word_gap_extra_units;
          end
        end
      end
      KIND_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (t_inc >= (TICK_BITS + 1)'(len_ext)) begin
            tick_d  = '0;
            units_d = units_dec;
            if (units_dec == 3'd0) begin
              case (phase_q)
                PH_MARK: begin
                  phase_d = PH_ESPACE;
                  units_d = 3'd1;
                end
                PH_ESPACE: begin
                  if (elem_q != 3'd0) begin
                    pat_d   = es_cur.pattern;
                    elem_d  = es_cur.elements;
                    units_d = es_cur.units;
                    phase_d = PH_MARK;
                  end else if (gap_letter == 3'd0) begin
                    phase_d = PH_IDLE;
                    units_d = 3'd0;
                  end else begin
                    phase_d = PH_GAP;
                    units_d = gap_letter;
                  end
                end
                default: begin
                  phase_d = PH_IDLE;
                  units_d = 3'd0;
                end
              endcase
            end
          end else begin
            tick_d = t_inc[TICK_BITS-1:0];
          end
        end
      end
      default: begin
        rej_d = 1'b0;
      end
    endcase
    led_d  = (phase_d == PH_MARK) ^ cfg_i.invert_led;
    busy_d = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      units_q     <= 3'd0;
      pat_q       <= 5'd0;
      elem_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_pop_o) begin
        phase_q     <= phase_d;
        tick_q      <= tick_d;
        units_q     <= units_d;
        pat_q       <= pat_d;
        elem_q      <= elem_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      led_q  <= led_d;
      busy_q <= busy_d;
      rej_q  <= rej_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign led_level_o = led_q;
  assign busy_res_o  = busy_q;
  assign rejected_o  = rej_q;

  a_idle_no_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (units_q == 3'd0))
    else $error("idle phase with units left");

  a_mark_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MARK) |-> (units_q != 3'd0))
    else $error("mark phase with no units left");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rej_q) |-> busy_q)
    else $error("rejected result while not busy");

  a_letter_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_pop_o && (item_i.kind == KIND_LETTER) && (phase_q == PH_IDLE))
      |=> (phase_q == PH_MARK))
    else $error("accepted letter did not start a mark");

endmodule
`default_nettype wire

// ----- rtl/morse_char_keyer.sv -----
// Top level of the Morse keyer: configuration registers and front/queue/back wiring.
// Result path: an accepted item is stored in the queue, then its result in the output register.
// Throughput: one item per cycle unless the result channel stalls; back end steps once per item.
// The input side keeps accepting while a result waits, until the two-entry queue fills.
// Reset: asynchronous active low; registers take their defaults, keyer idle, queue empty.
`default_nettype none
module morse_char_keyer
  import mck_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input item channel
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       op_i,
  input  wire logic [7:0] char_code_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            led_level_o,
  output logic            busy_res_o,
  output logic            rejected_o,
  // configuration write channel
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  cfg_t  cfg_q;
  item_t front_item;
  item_t head_item;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  logic  in_xfer;

  // Configuration writes are always taken; the user must send them only while the keyer is idle (not enforced here)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_ticks           <= UNIT_TICKS_RST;
      cfg_q.dash_units           <= DASH_UNITS_RST;
      cfg_q.letter_gap_units     <= LETTER_GAP_RST;
      cfg_q.word_gap_extra_units <= WORD_GAP_RST;
      cfg_q.invert_led           <= INVERT_LED_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_UNIT_TICKS: cfg_q.unit_ticks           <= cfg_data_i;
        REG_DASH_UNITS: cfg_q.dash_units           <= cfg_data_i[2:0];
        REG_LETTER_GAP: cfg_q.letter_gap_units     <= cfg_data_i[2:0];
        REG_WORD_GAP:   cfg_q.word_gap_extra_units <= cfg_data_i[2:0];
        REG_INVERT_LED: cfg_q.invert_led           <= cfg_data_i[0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Hold off the input side only when the queue is full
  assign in_ready_o = !q_full;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Classify the item and fetch its code word before it is queued
  mck_front u_front (
    .op_i        (op_i),
    .char_code_i (char_code_i),
    .item_o      (front_item)
  );

  // Decouple input acceptance from result backpressure
  mck_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_xfer),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  // Advance the keyer timing one queued item per cycle unless the result channel stalls, and register the result
  mck_back #(
    .TICK_BITS (TICK_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (head_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .led_level_o  (led_level_o),
    .busy_res_o   (busy_res_o),
    .rejected_o   (rejected_o)
  );

endmodule
`default_nettype wire
